// File: sv/skf_pkg.sv
package skf_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned VAR_W    = 32;
    localparam int unsigned GAIN_W   = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

    // Reset values and the Q16 constant one.
    localparam logic [VAR_W-1:0]  PROCESS_NOISE_RST     = 32'd66;
    localparam logic [VAR_W-1:0]  MEASUREMENT_NOISE_RST = 32'd655;
    localparam logic [VAR_W-1:0]  VARIANCE_ONE          = 32'd65536;
    localparam logic [GAIN_W-1:0] GAIN_ONE              = 17'h10000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [VAR_W-1:0]    t_var;
    typedef logic        [GAIN_W-1:0]   t_gain;

endpackage

// File: sv/skf_smp_if.sv
interface skf_smp_if
    import skf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: sv/skf_res_if.sv
interface skf_res_if
    import skf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample estimate;
    t_gain   gain;
    t_var    variance;

    modport source (output valid, output estimate, output gain, output variance, input ready);
    modport sink   (input valid, input estimate, input gain, input variance, output ready);
endinterface

// File: sv/scalar_kalman_filter.sv
// Channel   Direction  Fields                          Transaction when
// i_smp     in         sample                          valid && ready
// o_res     out        estimate, gain, variance        valid && ready
// i_cfg     in         we, idx, data                   we high
//
// From acceptance to a loaded result register a sample passes through these steps:
// the predicted variance, the restoring divider for the gain (one quotient bit
// a cycle), the two products on the shared multiplier and the step that loads
// the result. i_smp.ready is high only while idle.
// A result waiting in the output register does not block the next sample;
// the block holds in its last step only if the previous result is still there.
// Reset is synchronous and active low.
module scalar_kalman_filter
    import skf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    skf_smp_if.sink               i_smp,
    skf_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_VAR,
        ST_FIN
    } t_state;

    t_state            r_state;
    t_var              r_process_noise;
    t_var              r_meas_noise;
    t_sample           r_est;
    t_var              r_var;
    t_sample           r_sample;
    t_var              r_pred;
    logic [VAR_W:0]    r_denom;
    logic signed [SAMPLE_W:0] r_diff;
    logic [VAR_W:0]    r_rem;
    t_gain             r_quo;
    logic [4:0]        r_cnt;
    logic [47:0]       r_prod;
    logic              r_out_valid;
    t_sample           r_out_est;
    t_gain             r_out_gain;
    t_var              r_out_var;

    logic [VAR_W:0]    w_sum;
    t_var              w_pred;
    logic [VAR_W+1:0]  w_trial;
    logic              w_fit;
    t_gain             w_gain;
    t_gain             w_mul_a;
    logic signed [SAMPLE_W:0] w_mul_b;
    logic signed [50:0] w_prod;
    t_sample           w_est_next;

    // Predicted variance, saturating at the top of the range.
    assign w_sum  = {1'b0, r_var} + {1'b0, r_process_noise};
    assign w_pred = w_sum[VAR_W] ? '1 : w_sum[VAR_W-1:0];

    // Restoring divider step: the first step compares without a shift.
    assign w_trial = (r_cnt == 5'd0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_fit   = (w_trial >= {1'b0, r_denom});

    // A zero denominator gives a zero gain.
    assign w_gain = (r_denom == '0) ? '0 : r_quo;

    // Shared multiplier: gain times difference, then (one - gain) times predicted.
    assign w_mul_a = (r_state == ST_MUL_EST) ? w_gain : GAIN_ONE - w_gain;
    assign w_mul_b = (r_state == ST_MUL_EST) ? r_diff : $signed({1'b0, r_pred});
    assign w_prod  = $signed({1'b0, w_mul_a}) * w_mul_b;

    // Floored product shifted down by 16 moves the estimate.
    assign w_est_next = r_est + $signed(r_prod[47:16]);

    assign i_smp.ready    = (r_state == ST_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.estimate = r_out_est;
    assign o_res.gain     = r_out_gain;
    assign o_res.variance = r_out_var;

    // Sequencer, state registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_process_noise <= PROCESS_NOISE_RST;
            r_meas_noise    <= MEASUREMENT_NOISE_RST;
            r_est           <= '0;
            r_var           <= VARIANCE_ONE;
            r_cnt           <= '0;
        end else begin
            // The final step reloads the result register itself.
            if (r_out_valid && o_res.ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            // Writes to the two noise registers reset the variance to one.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PROCESS_NOISE: begin
                        r_process_noise <= i_cfg_data;
                        r_var           <= VARIANCE_ONE;
                    end
                    REG_MEASUREMENT_NOISE: begin
                        r_meas_noise <= i_cfg_data;
                        r_var        <= VARIANCE_ONE;
                    end
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_smp.valid) begin
                        r_sample <= i_smp.sample;
                        r_state  <= ST_PRED;
                    end
                end
                ST_PRED: begin
                    r_pred  <= w_pred;
                    r_denom <= {1'b0, w_pred} + {1'b0, r_meas_noise};
                    r_rem   <= {1'b0, w_pred};
                    r_diff  <= {r_sample[SAMPLE_W-1], r_sample} - {r_est[SAMPLE_W-1], r_est};
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_fit) begin
                        r_rem <= w_trial[VAR_W:0] - r_denom;
                    end else begin
                        r_rem <= w_trial[VAR_W:0];
                    end
                    r_quo <= {r_quo[GAIN_W-2:0], w_fit};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(GAIN_W - 1)) begin
                        r_state <= ST_MUL_EST;
                    end
                end
                ST_MUL_EST: begin
                    r_prod  <= w_prod[47:0];
                    r_state <= ST_MUL_VAR;
                end
                ST_MUL_VAR: begin
                    r_est   <= w_est_next;
                    r_prod  <= w_prod[47:0];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_var       <= r_prod[47:16];
                        r_out_est   <= r_est;
                        r_out_gain  <= w_gain;
                        r_out_var   <= r_prod[47:16];
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/skf_checker.sv
module skf_checker
    import skf_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_gain   i_out_gain,
    input t_sample i_out_estimate
);

    // The block works on one sample at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("sample accepted while a sample is in progress");

    // A result never appears in the cycle right after a sample is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // The gain never exceeds one.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_gain <= GAIN_ONE))
        else $error("gain above one");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_gain) && $stable(i_out_estimate)))
        else $error("stalled result changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_smp.valid),
    .i_in_ready     (i_smp.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_gain     (o_res.gain),
    .i_out_estimate (o_res.estimate)
);

// File: tb/tb_top.sv
module tb_top
    import skf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Run length and timing.
    localparam int N_ITEMS      = 1550;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int MAX_REPORTS   = 10;

    // Register indexes that the block decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

    localparam t_sample SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam t_sample SAMPLE_MIN = 32'sh8000_0000;
    localparam t_var    NOISE_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        t_sample estimate;
        t_gain   gain;
        t_var    variance;
    } t_kf_result;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_CHOKED} t_rx_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    skf_smp_if smp_if ();
    skf_res_if res_if ();

    scalar_kalman_filter uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Filter state and registers as the block should hold them.
    t_var    q_noise;
    t_var    r_noise;
    t_sample est;
    t_var    err_var;

    t_kf_result expected_q[$];
    int         n_sent;
    int         n_mismatch;
    int         burst_left;

    // One filter step: predict, form the gain, correct estimate and variance.
    function automatic t_kf_result kalman_update(input t_sample x);
        logic [32:0] pred_sum;
        logic [31:0] pred;
        logic [32:0] denom;
        logic [63:0] quot;
        t_gain       k;
        longint      diff;
        longint      prod;
        longint      next_est;
        logic [63:0] shrink;
        t_kf_result  r;
        pred_sum = {1'b0, err_var} + {1'b0, q_noise};
        pred     = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
        denom    = {1'b0, pred} + {1'b0, r_noise};
        if (denom == '0) begin
            quot = '0;
        end else begin
            quot = {16'b0, pred, 16'b0} / {31'b0, denom};
        end
        k        = (quot > 64'd65536) ? GAIN_ONE : quot[GAIN_W-1:0];
        diff     = longint'(x) - longint'(est);
        prod     = longint'(k) * diff;
        // The arithmetic shift floors toward minus infinity.
        next_est = longint'(est) + (prod >>> 16);
        shrink   = (64'd65536 - {47'b0, k}) * {32'b0, pred};
        est      = next_est[31:0];
        err_var  = shrink[47:16];
        r.estimate = next_est[31:0];
        r.gain     = k;
        r.variance = shrink[47:16];
        return r;
    endfunction

    // Drives one register write; the enable stays high until stop_writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_var data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == REG_PROCESS_NOISE) begin
            q_noise = data;
            err_var = VARIANCE_ONE;
        end else if (idx == REG_MEASUREMENT_NOISE) begin
            r_noise = data;
            err_var = VARIANCE_ONE;
        end
    endtask

    task automatic stop_writes();
        cfg_we <= 1'b0;
    endtask

    // Sends one sample in bursts with random gaps, and records its result.
    task automatic send_sample(input t_sample x);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= x;
        do @(posedge clk); while (!smp_if.ready);
        expected_q.push_back(kalman_update(x));
        n_sent++;
        burst_left--;
    endtask

    // Lets the block run dry so that registers may be written safely.
    task automatic wait_idle(input int extra);
        smp_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Samples: full range, near the current estimate, extremes, small values.
    function automatic t_sample pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return t_sample'($urandom);
        end else if (r < 70) begin
            return est + t_sample'($urandom_range(0, 1 << 20)) - t_sample'(1 << 19);
        end else if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return '0;
                default: return -1;
            endcase
        end else begin
            return t_sample'($urandom_range(0, 1 << 24)) - t_sample'(1 << 23);
        end
    endfunction

    // Noise settings: zero, the maximum, typical small values and full range.
    function automatic t_var pick_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return NOISE_MAX;
        end else if (r < 55) begin
            return t_var'($urandom_range(1, 1 << 17));
        end else if (r < 75) begin
            return t_var'($urandom_range(0, 1 << 24));
        end else begin
            return t_var'($urandom);
        end
    endfunction

    // Reset values of the registers, and the full sample range.
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(-1);
        send_sample(1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
    endtask

    // With both noises at zero the gain becomes one, then the divisor is zero.
    task automatic test_zero_denominator();
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_MEASUREMENT_NOISE, '0);
        stop_writes();
        send_sample(32'sh0001_0000);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
    endtask

    // Maximum process noise saturates the predicted variance, under maximum and then zero measurement noise.
    task automatic test_saturation();
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_PROCESS_NOISE, NOISE_MAX);
        write_reg(REG_MEASUREMENT_NOISE, NOISE_MAX);
        stop_writes();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(32'sh1234_5678);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_MEASUREMENT_NOISE, '0);
        stop_writes();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
    endtask

    // Writes to undecoded indexes must leave registers and variance alone.
    task automatic test_unused_index();
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_PROCESS_NOISE, 32'd300);
        write_reg(REG_MEASUREMENT_NOISE, 32'd5000);
        stop_writes();
        send_sample(32'sh0002_0000);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_UNUSED_LO, NOISE_MAX);
        write_reg(REG_UNUSED_HI, 32'hA5A5_5A5A);
        write_reg(REG_UNUSED_LO, '0);
        stop_writes();
        send_sample(32'sh0003_0000);
        send_sample(-32'sh0001_0000);
    endtask

    // Phases of random samples, each under a fresh random noise setting.
    task automatic test_random_phases();
        int n;
        int r;
        while (n_sent < N_ITEMS) begin
            wait_idle(SETTLE_CYCLES);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                write_reg(REG_PROCESS_NOISE, pick_noise());
            end
            if (r >= 4) begin
                write_reg(REG_MEASUREMENT_NOISE, pick_noise());
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                          t_var'($urandom));
            end
            stop_writes();
            n = $urandom_range(10, 90);
            repeat (n) send_sample(pick_sample());
        end
    endtask

    // Result side: stall pattern and in-order comparison against expectations.
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int unsigned rx_tick = 0;

    always @(posedge clk) begin
        t_kf_result e;
        logic       bad;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS) begin
                    $display("%0t unexpected result: est %0d gain %0d variance %0d",
                             $realtime, res_if.estimate, res_if.gain, res_if.variance);
                end
            end else begin
                e   = expected_q.pop_front();
                bad = (res_if.estimate !== e.estimate) || (res_if.gain !== e.gain)
                      || (res_if.variance !== e.variance);
                if (bad) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS) begin
                        $display("%0t mismatch: expected est %0d gain %0d variance %0d",
                                 $realtime, e.estimate, e.gain, e.variance);
                        $display("%0t           got      est %0d gain %0d variance %0d",
                                 $realtime, res_if.estimate, res_if.gain,
                                 res_if.variance);
                    end
                end
            end
        end

        // Switch the stall mode now and then.
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   res_if.ready <= 1'b1;
            RX_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: res_if.ready <= (rx_tick[2:0] == 3'd0);
            default:   res_if.ready <= (rx_tick[5:0] == 6'd0);
        endcase
    end

    initial begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= REG_PROCESS_NOISE;
        cfg_data      <= '0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        q_noise    = PROCESS_NOISE_RST;
        r_noise    = MEASUREMENT_NOISE_RST;
        est        = '0;
        err_var    = VARIANCE_ONE;
        n_sent     = 0;
        n_mismatch = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_denominator();
        test_saturation();
        test_unused_index();
        test_random_phases();

        wait_idle(DRAIN_CYCLES);
        if (n_mismatch == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #8ms;
        $display("status: fail");
        $finish;
    end

endmodule
